FILE: design/jpeg_frame_size_sniffer_assert.svh
// assertion macros used by the sniffer parser module
`ifndef JPEG_FRAME_SIZE_SNIFFER_ASSERT_SVH
`define JPEG_FRAME_SIZE_SNIFFER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JFSS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("jfss same-cycle check failed");

// next-cycle implication, checked out of reset
`define JFSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("jfss next-cycle check failed");

`endif

FILE: design/jfss_pkg.sv
// types, constants and parse phase codes for the jpeg frame size sniffer
`default_nettype none
package jfss_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DIM_W    = 16;
    localparam int unsigned KIND_W   = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PHASE_W  = 4;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [BYTE_W-1:0] BYTE_FF  = 8'hff;
    localparam logic [BYTE_W-1:0] BYTE_D8  = 8'hd8;
    localparam logic [BYTE_W-1:0] SOF_LOW  = 8'hc0;
    localparam logic [BYTE_W-1:0] SOF_END  = 8'hd0;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_JPEG  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [PHASE_W-1:0] PH_START0    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START1    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SCAN      = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP0     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP1     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SKIP2     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_HEIGHT_HI = 4'd6;
    localparam logic [PHASE_W-1:0] PH_HEIGHT_LO = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WIDTH_HI  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_WIDTH_LO  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_DONE      = 4'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_file;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [KIND_W-1:0]   frame_kind;
        logic                is_landscape;
    } result_t;

endpackage
`default_nettype wire

FILE: design/jfss_in_stage.sv
// input register holding one byte request until the parser takes it
`default_nettype none
module jfss_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire jfss_pkg::item_t in_item,
    input  wire logic           advance,
    output logic                item_valid,
    output jfss_pkg::item_t     item
);
    import jfss_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

FILE: design/jfss_parser.sv
// marker scan state machine and dimension assembly for one byte per cycle while advance is high
`default_nettype none
module jfss_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire jfss_pkg::item_t item,
    input  wire logic            advance,
    output logic                 emit,
    output jfss_pkg::result_t    result
);
    import jfss_pkg::*;
    `include "jpeg_frame_size_sniffer_assert.svh"

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               prior_ff_reg, prior_ff_next;
    logic [BYTE_W-1:0]  upper_reg, upper_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [KIND_W-1:0]  nibble_reg, nibble_next;

    logic [BYTE_W-1:0]   b;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    width_val;
    logic [PHASE_W-1:0]  phase_step;

    assign b         = item.data_byte;
    assign width_val = {upper_reg, b};

    always_comb begin
        phase_step    = phase_reg;
        prior_ff_next = prior_ff_reg;
        upper_next    = upper_reg;
        height_next   = height_reg;
        nibble_next   = nibble_reg;
        hit           = 1'b0;
        status        = STATUS_OK;
        unique case (phase_reg)
            PH_START0: begin
                if (b == BYTE_FF) begin
                    phase_step = PH_START1;
                end else begin
                    hit        = 1'b1;
                    status     = STATUS_NOT_JPEG;
                    phase_step = PH_DONE;
                end
            end
            PH_START1: begin
                if (b == BYTE_D8) begin
                    phase_step    = PH_SCAN;
                    prior_ff_next = 1'b1;
                end else begin
                    hit        = 1'b1;
                    status     = STATUS_NOT_JPEG;
                    phase_step = PH_DONE;
                end
            end
            PH_SCAN: begin
                if (prior_ff_reg && b >= SOF_LOW && b < SOF_END) begin
                    nibble_next = b[KIND_W-1:0];
                    phase_step  = PH_SKIP0;
                end else begin
                    prior_ff_next = (b == BYTE_FF);
                end
            end
            PH_SKIP0, PH_SKIP1, PH_SKIP2: begin
                phase_step = phase_reg + PHASE_W'(1);
            end
            PH_HEIGHT_HI, PH_WIDTH_HI: begin
                upper_next = b;
                phase_step = phase_reg + PHASE_W'(1);
            end
            PH_HEIGHT_LO: begin
                height_next = {upper_reg, b};
                phase_step  = PH_WIDTH_HI;
            end
            PH_WIDTH_LO: begin
                hit        = 1'b1;
                status     = STATUS_OK;
                phase_step = PH_DONE;
            end
            default: begin
                phase_step = PH_DONE;
            end
        endcase

        phase_next = phase_step;
        if (item.end_of_file) begin
            if (!hit && phase_step != PH_DONE) begin
                hit    = 1'b1;
                status = (phase_step == PH_START1) ? STATUS_NOT_JPEG : STATUS_TRUNCATED;
            end
            phase_next    = PH_START0;
            prior_ff_next = 1'b0;
        end
    end

    assign emit = item_valid && hit;

    always_comb begin
        result.status       = status;
        result.width        = '0;
        result.height       = '0;
        result.frame_kind   = '0;
        result.is_landscape = 1'b0;
        if (status == STATUS_OK) begin
            result.width        = width_val;
            result.height       = height_reg;
            result.frame_kind   = nibble_reg;
            result.is_landscape = (width_val > height_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START0;
            prior_ff_reg <= 1'b0;
            upper_reg    <= '0;
            nibble_reg   <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            prior_ff_reg <= prior_ff_next;
            upper_reg    <= upper_next;
            nibble_reg   <= nibble_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            height_reg <= height_next;
        end
    end

    `JFSS_ASSERT_NOW(a_ok_only_at_width_lo, aclk, aresetn,
        emit && status == STATUS_OK, phase_reg == PH_WIDTH_LO)
    `JFSS_ASSERT_NOW(a_not_jpeg_only_in_start, aclk, aresetn,
        emit && status == STATUS_NOT_JPEG, phase_reg == PH_START0 || phase_reg == PH_START1)
    `JFSS_ASSERT_NEXT(a_eof_restarts, aclk, aresetn,
        advance && item.end_of_file, phase_reg == PH_START0 && !prior_ff_reg)
    `JFSS_ASSERT_NOW(a_advance_needs_item, aclk, aresetn, advance, item_valid)

endmodule
`default_nettype wire

FILE: design/jfss_out_stage.sv
// result register feeding the master side
`default_nettype none
module jfss_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire jfss_pkg::result_t result,
    output logic                   slot_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output jfss_pkg::result_t      out_result
);
    import jfss_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

FILE: design/jpeg_frame_size_sniffer.sv
// top level of the jpeg frame size sniffer
//
// slave side takes one file byte per request: s_tdata is the byte, s_tlast marks
// the last byte of a file. after s_tlast the parser restarts for the next file.
// master side gives one request per file: m_tuser is the status (found, not a
// jpeg start, truncated), m_tdata holds width, height, frame kind and the
// landscape flag; sizes and kind are zero unless the status is found.
// path: a byte is first held in the input register, the parser decodes it
// combinationally, and the result that it completes is written to the output
// register that drives m_tvalid.
// throughput: one byte per cycle, set by the parser state update, except when held as below.
// when m_tready is low with a result waiting, bytes that give no result keep
// flowing; the byte that completes the next file holds in the input register
// until the output register is free.
// reset (aresetn low, synchronous) empties both registers and returns the parser
// to looking for the ff d8 start bytes.
`default_nettype none
module jpeg_frame_size_sniffer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [jfss_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [jfss_pkg::M_DATA_W-1:0]      m_tdata,  // [15:0] width, [31:16] height,
                                                         // [35:32] frame_kind,
                                                         // [36] is_landscape, rest zero
    output logic [jfss_pkg::STATUS_W-1:0]      m_tuser   // [1:0] status
);
    import jfss_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    emit;
    logic    slot_free;
    result_t result;
    result_t out_result;

    assign in_item.data_byte   = s_tdata[BYTE_W-1:0];
    assign in_item.end_of_file = s_tlast;

    assign advance = item_valid && (!emit || slot_free);

    jfss_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jfss_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .emit       (emit),
        .result     (result)
    );

    jfss_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && emit),
        .result     (result),
        .slot_free  (slot_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_result (out_result)
    );

    assign m_tuser = out_result.status;
    assign m_tdata = {3'b000, out_result.is_landscape, out_result.frame_kind,
                      out_result.height, out_result.width};

endmodule
`default_nettype wire
